// ===== sv/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// bbc_pkg: shared types and constants of the beam counter
// Register indexes, reset values, event codes and the bundles that travel
// between the configuration block, the core and the top level.
// ----------------------------------------------------------------------------
package bbc_pkg;

    localparam int TIME_W     = 32;
    localparam int READING_W  = 10;
    localparam int THR_W      = 10;
    localparam int WINDOW_W   = 16;
    localparam int TIMEOUT_W  = 20;
    localparam int HOLDOFF_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int COUNT_OUT_W = 16;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALIGN_TIMEOUT_MS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_MS       = 3'd4;

    // reset values of the registers
    localparam logic [THR_W-1:0]     RST_THRESHOLD     = 10'd200;
    localparam logic [WINDOW_W-1:0]  RST_WINDOW_MS     = 16'd2000;
    localparam logic [TIMEOUT_W-1:0] RST_ALIGN_TIMEOUT = 20'd20000;
    localparam logic [HOLDOFF_W-1:0] RST_HOLDOFF_MS    = 16'd500;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_ENTRY = 2'd1,
        EV_EXIT  = 2'd2
    } t_event;

    typedef struct packed {
        logic [THR_W-1:0]     threshold_left;
        logic [THR_W-1:0]     threshold_right;
        logic [WINDOW_W-1:0]  window_ms;
        logic [TIMEOUT_W-1:0] align_timeout_ms;
        logic [HOLDOFF_W-1:0] holdoff_ms;
    } t_cfg;

    typedef struct packed {
        t_event                 event_res;
        logic                   aligning;
        logic                   obstructed_left;
        logic                   obstructed_right;
        logic [COUNT_OUT_W-1:0] count_in;
        logic [COUNT_OUT_W-1:0] count_out;
    } t_result;

endpackage

// ===== sv/bbc_cfg.sv =====
// ----------------------------------------------------------------------------
// bbc_cfg: configuration register file
// Holds the thresholds and timing registers; takes one write per cycle.
// ----------------------------------------------------------------------------
module bbc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bbc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bbc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output bbc_pkg::t_cfg                  o_cfg
);
    import bbc_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold_left   <= RST_THRESHOLD;
            r_cfg.threshold_right  <= RST_THRESHOLD;
            r_cfg.window_ms        <= RST_WINDOW_MS;
            r_cfg.align_timeout_ms <= RST_ALIGN_TIMEOUT;
            r_cfg.holdoff_ms       <= RST_HOLDOFF_MS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_THRESHOLD_LEFT:   r_cfg.threshold_left   <= i_cfg_data[THR_W-1:0];
                REG_THRESHOLD_RIGHT:  r_cfg.threshold_right  <= i_cfg_data[THR_W-1:0];
                REG_WINDOW_MS:        r_cfg.window_ms        <= i_cfg_data[WINDOW_W-1:0];
                REG_ALIGN_TIMEOUT_MS: r_cfg.align_timeout_ms <= i_cfg_data[TIMEOUT_W-1:0];
                REG_HOLDOFF_MS:       r_cfg.holdoff_ms       <= i_cfg_data[HOLDOFF_W-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

endmodule

// ===== sv/bbc_core.sv =====
// ----------------------------------------------------------------------------
// bbc_core: per-sample decision logic and tracking state
// Evaluates one registered sample against the held state and commits the
// new state when the sample moves on to the result register.
// ----------------------------------------------------------------------------
module bbc_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  bbc_pkg::t_cfg                 i_cfg,
    input  logic [bbc_pkg::TIME_W-1:0]    i_now_ms,
    input  logic [bbc_pkg::READING_W-1:0] i_reading_left,
    input  logic [bbc_pkg::READING_W-1:0] i_reading_right,
    output bbc_pkg::t_result              o_res
);
    import bbc_pkg::*;

    logic [TIME_W-1:0]      r_obs_time_l, r_obs_time_r, n_obs_time_l, n_obs_time_r;
    logic                   r_stale_l, r_stale_r, n_stale_l, n_stale_r;
    logic [TIME_W-1:0]      r_laser_l, r_laser_r, n_laser_l, n_laser_r;
    logic                   r_align, n_align;
    logic [TIME_W-1:0]      r_hold_start, n_hold_start;
    logic                   r_hold_active, n_hold_active;
    logic [COUNT_WIDTH-1:0] r_entries, r_exits, n_entries, n_exits;

    logic                   obl, obr;
    logic                   held;
    logic [TIME_W-1:0]      age_hold, age_l, age_r, age_las_l, age_las_r;
    logic                   valid_l, valid_r;
    logic                   guard_ok, misaligned;
    t_event                 ev;

    always_comb begin
        obl      = i_reading_left > i_cfg.threshold_left;
        obr      = i_reading_right > i_cfg.threshold_right;
        age_hold = i_now_ms - r_hold_start;
        held     = r_hold_active && (age_hold < TIME_W'(i_cfg.holdoff_ms));

        n_obs_time_l  = r_obs_time_l;
        n_obs_time_r  = r_obs_time_r;
        n_stale_l     = r_stale_l;
        n_stale_r     = r_stale_r;
        n_laser_l     = r_laser_l;
        n_laser_r     = r_laser_r;
        n_align       = r_align;
        n_hold_start  = r_hold_start;
        n_hold_active = r_hold_active;
        n_entries     = r_entries;
        n_exits       = r_exits;
        ev            = EV_NONE;

        // fresh obstructions take the current time
        if (obl) begin
            n_obs_time_l = i_now_ms;
            n_stale_l    = 1'b0;
        end
        if (obr) begin
            n_obs_time_r = i_now_ms;
            n_stale_r    = 1'b0;
        end
        age_l   = i_now_ms - n_obs_time_l;
        age_r   = i_now_ms - n_obs_time_r;
        valid_l = !n_stale_l && (age_l < TIME_W'(i_cfg.window_ms));
        valid_r = !n_stale_r && (age_r < TIME_W'(i_cfg.window_ms));

        if (!obl) n_laser_l = i_now_ms;
        if (!obr) n_laser_r = i_now_ms;
        age_las_l  = i_now_ms - n_laser_l;
        age_las_r  = i_now_ms - n_laser_r;
        misaligned = (age_las_l > TIME_W'(i_cfg.align_timeout_ms)) ||
                     (age_las_r > TIME_W'(i_cfg.align_timeout_ms));
        guard_ok   = i_now_ms > TIME_W'({i_cfg.window_ms, 1'b0});

        if (held) begin
            // ignore the sample entirely
            n_obs_time_l = r_obs_time_l;
            n_obs_time_r = r_obs_time_r;
            n_stale_l    = r_stale_l;
            n_stale_r    = r_stale_r;
            n_laser_l    = r_laser_l;
            n_laser_r    = r_laser_r;
        end else begin
            n_hold_active = 1'b0;
            if (r_align) begin
                n_laser_l = r_laser_l;
                n_laser_r = r_laser_r;
                if (!valid_l && !valid_r) begin
                    n_align   = 1'b0;
                    n_laser_l = i_now_ms;
                    n_laser_r = i_now_ms;
                end
            end else if (misaligned) begin
                n_align = 1'b1;
            end else if (valid_l && valid_r && guard_ok && !(obl && obr)) begin
                if (age_r < age_l) begin
                    ev = EV_ENTRY;
                    if (!(&r_entries)) n_entries = r_entries + 1'b1;
                end else if (age_l < age_r) begin
                    ev = EV_EXIT;
                    if (!(&r_exits)) n_exits = r_exits + 1'b1;
                end
                if (ev != EV_NONE) begin
                    n_stale_l     = 1'b1;
                    n_stale_r     = 1'b1;
                    n_hold_active = 1'b1;
                    n_hold_start  = i_now_ms;
                end
            end
        end

        o_res.event_res        = ev;
        o_res.aligning         = n_align;
        o_res.obstructed_left  = obl;
        o_res.obstructed_right = obr;
        o_res.count_in         = COUNT_OUT_W'(n_entries);
        o_res.count_out        = COUNT_OUT_W'(n_exits);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obs_time_l  <= '0;
            r_obs_time_r  <= '0;
            r_stale_l     <= 1'b1;
            r_stale_r     <= 1'b1;
            r_laser_l     <= '0;
            r_laser_r     <= '0;
            r_align       <= 1'b0;
            r_hold_start  <= '0;
            r_hold_active <= 1'b0;
            r_entries     <= '0;
            r_exits       <= '0;
        end else if (i_fire) begin
            r_obs_time_l  <= n_obs_time_l;
            r_obs_time_r  <= n_obs_time_r;
            r_stale_l     <= n_stale_l;
            r_stale_r     <= n_stale_r;
            r_laser_l     <= n_laser_l;
            r_laser_r     <= n_laser_r;
            r_align       <= n_align;
            r_hold_start  <= n_hold_start;
            r_hold_active <= n_hold_active;
            r_entries     <= n_entries;
            r_exits       <= n_exits;
        end
    end

endmodule

// ===== sv/bidirectional_beam_counter_unit.sv =====
// ----------------------------------------------------------------------------
// bidirectional_beam_counter_unit: two-beam entry/exit counter
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one timestamped pair of
//   beam readings per transfer. Output channel (o_out_valid / i_out_stall)
//   returns exactly one result per input transfer: event code, aligning
//   flag, both obstruction flags and the entry/exit counters.
//   Configuration writes arrive on i_cfg_valid / o_cfg_ready with a
//   register index and data; the port is always ready. Write only while
//   the block is idle.
//   Path: each sample passes the input register, the core's combinational
//   state update, then the result register, which drives o_out_valid.
//   Throughput: one item per cycle while the receiver does not stall; the
//   core's state update lies between the two registers.
//   A stalled receiver holds the result register; the input register still
//   takes one more transfer if it was empty, after which o_in_stall rises.
//   Reset (synchronous, active low) empties both registers, restores the
//   register defaults and clears the counters and tracking state.
// ----------------------------------------------------------------------------
module bidirectional_beam_counter_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // sample input
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [bbc_pkg::TIME_W-1:0]     i_now_ms,
    input  logic [bbc_pkg::READING_W-1:0]  i_reading_left,
    input  logic [bbc_pkg::READING_W-1:0]  i_reading_right,
    // result output
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [1:0]                     o_event_res,
    output logic                           o_aligning,
    output logic                           o_obstructed_left,
    output logic                           o_obstructed_right,
    output logic [bbc_pkg::COUNT_OUT_W-1:0] o_count_in,
    output logic [bbc_pkg::COUNT_OUT_W-1:0] o_count_out,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bbc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bbc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bbc_pkg::*;

    t_cfg                 cfg;
    t_result              core_res;

    logic                 r_in_valid;
    logic [TIME_W-1:0]    r_now_ms;
    logic [READING_W-1:0] r_reading_l, r_reading_r;

    logic                 r_out_valid;
    t_result              r_res;

    logic                 advance;
    logic                 fire;
    logic                 in_take;

    // the result register frees up when empty or when its transfer completes
    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    bbc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bbc_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_cfg           (cfg),
        .i_now_ms        (r_now_ms),
        .i_reading_left  (r_reading_l),
        .i_reading_right (r_reading_r),
        .o_res           (core_res)
    );

    // input register: hold the sample until the core commits it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_now_ms    <= i_now_ms;
            r_reading_l <= i_reading_left;
            r_reading_r <= i_reading_right;
        end
    end

    // result register: advance on commit, drop after transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= core_res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_event_res        = r_res.event_res;
    assign o_aligning         = r_res.aligning;
    assign o_obstructed_left  = r_res.obstructed_left;
    assign o_obstructed_right = r_res.obstructed_right;
    assign o_count_in         = r_res.count_in;
    assign o_count_out        = r_res.count_out;

endmodule
